>>> hdl/iewe_pkg.sv
// Shared types and constants for the input event word encoder.
`default_nettype none
package iewe_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MAX_WORDS   = 9;
  localparam int unsigned WORD_IDX_W  = $clog2(MAX_WORDS);
  localparam int unsigned WORD_CNT_W  = $clog2(MAX_WORDS + 1);

  // event kinds on the func field
  localparam logic [1:0] FUNC_KEY     = 2'd0;
  localparam logic [1:0] FUNC_BUTTON  = 2'd1;
  localparam logic [1:0] FUNC_POINTER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_INPUT_ENABLED    = 2'd0;
  localparam logic [1:0] CFG_POINTER_OFFSET_X = 2'd1;
  localparam logic [1:0] CFG_POINTER_OFFSET_Y = 2'd2;

  // event word types
  localparam logic [3:0] WT_DELTA = 4'd0;
  localparam logic [3:0] WT_X     = 4'd1;
  localparam logic [3:0] WT_Y     = 4'd2;
  localparam logic [3:0] WT_DOWN  = 4'd3;
  localparam logic [3:0] WT_UP    = 4'd4;
  localparam logic [3:0] WT_ABS   = 4'd5;

  localparam logic [7:0]  CODE_MOD_BIT0    = 8'd138;
  localparam logic [7:0]  CODE_MOD_BIT1    = 8'd136;
  localparam logic [7:0]  CODE_BUTTON_BIT0 = 8'd130;
  localparam logic [7:0]  CODE_BUTTON_BIT1 = 8'd128;
  localparam logic [7:0]  CODE_BUTTON_BIT2 = 8'd129;
  localparam logic [31:0] TIME_EPOCH_SHIFT = 32'd2177452800;

  typedef enum logic [1:0] {
    CMD_KEY,
    CMD_BUTTON,
    CMD_POINTER
  } cmd_kind_t;

  // one classified event, waiting for expansion into words
  typedef struct packed {
    cmd_kind_t   kind;
    logic        long_stamp;
    logic [11:0] delta;
    logic [31:0] epoch_secs;
    logic [1:0]  mods;
    logic [7:0]  key;
    logic        btn_down;
    logic [7:0]  btn_code;
    logic [11:0] px;
    logic [11:0] py;
  } cmd_t;

endpackage
`default_nettype wire

>>> hdl/iewe_front.sv
// Front end: accepts events, filters and classifies them, keeps time and button state.
`default_nettype none
module iewe_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               input_enabled,
  input  wire logic [11:0]        pointer_offset_x,
  input  wire logic [11:0]        pointer_offset_y,
  input  wire logic               event_valid,
  output logic                    event_stall,
  input  wire logic [1:0]         func,
  input  wire logic [7:0]         key_code,
  input  wire logic [7:0]         modifier_bits,
  input  wire logic [2:0]         button_state,
  input  wire logic [11:0]        pointer_x,
  input  wire logic [11:0]        pointer_y,
  input  wire logic [31:0]        now_ms,
  input  wire logic [31:0]        unix_seconds,
  input  wire logic               queue_full,
  output logic                    push,
  output iewe_pkg::cmd_t          push_cmd
);

  logic [31:0] last_event_ms;
  logic        any_event_seen;
  logic [2:0]  previous_buttons;

  logic        accept;
  logic        wanted;
  logic [31:0] delta_full;
  logic [2:0]  changed;

  assign event_stall = queue_full;
  assign accept      = event_valid && !queue_full;
  assign changed     = button_state ^ previous_buttons;
  assign delta_full  = any_event_seen ? (now_ms - last_event_ms) : '0;

  always_comb begin
    wanted            = 1'b0;
    push_cmd          = '0;
    push_cmd.kind     = iewe_pkg::CMD_KEY;
    push_cmd.long_stamp = |delta_full[31:12];
    push_cmd.delta    = delta_full[11:0];
    push_cmd.epoch_secs = unix_seconds + iewe_pkg::TIME_EPOCH_SHIFT;
    push_cmd.mods     = modifier_bits[1:0];
    push_cmd.key      = key_code;
    push_cmd.px       = pointer_x - pointer_offset_x;
    push_cmd.py       = pointer_y - pointer_offset_y;
    // highest changed button wins
    if (changed[2]) begin
      push_cmd.btn_code = iewe_pkg::CODE_BUTTON_BIT2;
      push_cmd.btn_down = button_state[2];
    end else if (changed[1]) begin
      push_cmd.btn_code = iewe_pkg::CODE_BUTTON_BIT1;
      push_cmd.btn_down = button_state[1];
    end else begin
      push_cmd.btn_code = iewe_pkg::CODE_BUTTON_BIT0;
      push_cmd.btn_down = button_state[0];
    end
    case (func)
      iewe_pkg::FUNC_KEY: begin
        push_cmd.kind = iewe_pkg::CMD_KEY;
        wanted = (key_code != 8'd0) && (modifier_bits[7:2] == 6'd0);
      end
      iewe_pkg::FUNC_BUTTON: begin
        push_cmd.kind = iewe_pkg::CMD_BUTTON;
        wanted = (changed != 3'd0);
      end
      iewe_pkg::FUNC_POINTER: begin
        push_cmd.kind = iewe_pkg::CMD_POINTER;
        wanted = 1'b1;
      end
      default: wanted = 1'b0;
    endcase
  end

  assign push = accept && input_enabled && wanted;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_event_ms    <= '0;
      any_event_seen   <= 1'b0;
      previous_buttons <= '0;
    end else if (push) begin
      last_event_ms  <= now_ms;
      any_event_seen <= 1'b1;
      if (func == iewe_pkg::FUNC_BUTTON) begin
        previous_buttons <= button_state;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/iewe_queue.sv
// Small command queue between front end and word sequencer.
`default_nettype none
module iewe_queue #(
  parameter int unsigned DEPTH = iewe_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire iewe_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output iewe_pkg::cmd_t      head_cmd,
  output logic                not_empty,
  output logic                full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  iewe_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/iewe_back.sv
// Back end: builds a command's word list, streams it one word a cycle unless stalled.
`default_nettype none
module iewe_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire iewe_pkg::cmd_t       head_cmd,
  input  wire logic                 cmd_valid,
  output logic                      pop,
  output logic                      word_valid,
  input  wire logic                 word_stall,
  output logic [15:0]               event_word,
  output logic                      last_word
);

  localparam int unsigned NW = iewe_pkg::MAX_WORDS;
  localparam int unsigned IW = iewe_pkg::WORD_IDX_W;
  localparam int unsigned CW = iewe_pkg::WORD_CNT_W;

  logic [15:0]   list [NW];
  logic [CW-1:0] list_n;

  logic [15:0]   words [NW];
  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic          busy;
  logic          adv;
  logic          at_last;

  // word list of the queue head
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      list[i] = '0;
    end
    list_n = '0;
    if (head_cmd.long_stamp) begin
      list[0] = {iewe_pkg::WT_ABS, 12'd0};
      list[1] = head_cmd.epoch_secs[31:16];
      list[2] = head_cmd.epoch_secs[15:0];
      list_n  = CW'(3);
    end else begin
      list[0] = {iewe_pkg::WT_DELTA, head_cmd.delta};
      list_n  = CW'(1);
    end
    case (head_cmd.kind)
      iewe_pkg::CMD_KEY: begin
        if (head_cmd.mods[0]) begin
          list[list_n[IW-1:0]] = {iewe_pkg::WT_DOWN, 4'd0, iewe_pkg::CODE_MOD_BIT0};
          list_n = list_n + 1'b1;
        end
        if (head_cmd.mods[1]) begin
          list[list_n[IW-1:0]] = {iewe_pkg::WT_DOWN, 4'd0, iewe_pkg::CODE_MOD_BIT1};
          list_n = list_n + 1'b1;
        end
        list[list_n[IW-1:0]] = {iewe_pkg::WT_DOWN, 4'd0, head_cmd.key};
        list_n = list_n + 1'b1;
        list[list_n[IW-1:0]] = {iewe_pkg::WT_UP, 4'd0, head_cmd.key};
        list_n = list_n + 1'b1;
        if (head_cmd.mods[1]) begin
          list[list_n[IW-1:0]] = {iewe_pkg::WT_UP, 4'd0, iewe_pkg::CODE_MOD_BIT1};
          list_n = list_n + 1'b1;
        end
        if (head_cmd.mods[0]) begin
          list[list_n[IW-1:0]] = {iewe_pkg::WT_UP, 4'd0, iewe_pkg::CODE_MOD_BIT0};
          list_n = list_n + 1'b1;
        end
      end
      iewe_pkg::CMD_BUTTON: begin
        list[list_n[IW-1:0]] = {head_cmd.btn_down ? iewe_pkg::WT_DOWN : iewe_pkg::WT_UP,
                                4'd0, head_cmd.btn_code};
        list_n = list_n + 1'b1;
      end
      iewe_pkg::CMD_POINTER: begin
        // y stamp always has delta zero: same clock value
        list[list_n[IW-1:0]] = {iewe_pkg::WT_X, head_cmd.px};
        list_n = list_n + 1'b1;
        list[list_n[IW-1:0]] = {iewe_pkg::WT_DELTA, 12'd0};
        list_n = list_n + 1'b1;
        list[list_n[IW-1:0]] = {iewe_pkg::WT_Y, head_cmd.py};
        list_n = list_n + 1'b1;
      end
      default: list_n = list_n;
    endcase
  end

  assign adv     = !word_valid || !word_stall;
  assign at_last = (idx == cnt - 1'b1);
  assign pop     = cmd_valid && (!busy || (adv && at_last));

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < NW; i++) begin
        words[i] <= list[i];
      end
      cnt <= list_n;
    end
    if (adv && busy) begin
      event_word <= words[idx[IW-1:0]];
      last_word  <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= '0;
      word_valid <= 1'b0;
    end else begin
      if (adv) begin
        word_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (adv && busy) begin
        idx <= idx + 1'b1;
        if (at_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/input_event_word_encoder.sv
// Top level of the input event word encoder: config registers, front end, queue, back end.
//
// Usage:
//  - Input channel (event_valid / event_stall): one transaction per input event.
//    Disabled input, func 3, key code 0, modifiers above 3 and unchanged buttons
//    are taken and dropped without any word or state change.
//  - Output channel (word_valid / word_stall): one 16-bit event word per
//    transaction; last_word marks the final word of an event.
//  - Config port (cfg_write / cfg_index / cfg_data): write only while idle.
//  - The first word of an event passes the queue write, the load into the word
//    sequencer and the output register before it shows on the output.
//  - Throughput: one word per cycle from the sequencer while word_stall is low;
//    an event makes 2 to 9 words (key with both modifiers and a long
//    time stamp is 9). The sequencer loads the next command on the cycle of the
//    previous event's last word, so events stream without gaps.
//  - event_stall rises only when the command queue (QUEUE_DEPTH entries) is
//    full; dropped events are held off too while it is full.
//  - Reset (rst, synchronous) empties queue and sequencer, clears config,
//    time stamp and button state. A stalled word holds until taken.
`default_nettype none
module input_event_word_encoder #(
  parameter int unsigned QUEUE_DEPTH = iewe_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config port
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data,
  // event input channel
  input  wire logic        event_valid,
  output logic             event_stall,
  input  wire logic [1:0]  func,
  input  wire logic [7:0]  key_code,
  input  wire logic [7:0]  modifier_bits,
  input  wire logic [2:0]  button_state,
  input  wire logic [11:0] pointer_x,
  input  wire logic [11:0] pointer_y,
  input  wire logic [31:0] now_ms,
  input  wire logic [31:0] unix_seconds,
  // word output channel
  output logic             word_valid,
  input  wire logic        word_stall,
  output logic [15:0]      event_word,
  output logic             last_word
);

  logic        input_enabled;
  logic [11:0] pointer_offset_x;
  logic [11:0] pointer_offset_y;

  logic           push;
  iewe_pkg::cmd_t push_cmd;
  logic           pop;
  iewe_pkg::cmd_t head_cmd;
  logic           q_not_empty;
  logic           q_full;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_enabled    <= 1'b0;
      pointer_offset_x <= '0;
      pointer_offset_y <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        iewe_pkg::CFG_INPUT_ENABLED:    input_enabled    <= cfg_data[0];
        iewe_pkg::CFG_POINTER_OFFSET_X: pointer_offset_x <= cfg_data;
        iewe_pkg::CFG_POINTER_OFFSET_Y: pointer_offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter, time stamp bookkeeping, classification
  iewe_front u_front (
    .clk              (clk),
    .rst              (rst),
    .input_enabled    (input_enabled),
    .pointer_offset_x (pointer_offset_x),
    .pointer_offset_y (pointer_offset_y),
    .event_valid      (event_valid),
    .event_stall      (event_stall),
    .func             (func),
    .key_code         (key_code),
    .modifier_bits    (modifier_bits),
    .button_state     (button_state),
    .pointer_x        (pointer_x),
    .pointer_y        (pointer_y),
    .now_ms           (now_ms),
    .unix_seconds     (unix_seconds),
    .queue_full       (q_full),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  // decouples event intake from word output
  iewe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // word list expansion and output register
  iewe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_cmd   (head_cmd),
    .cmd_valid  (q_not_empty),
    .pop        (pop),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .event_word (event_word),
    .last_word  (last_word)
  );

endmodule
`default_nettype wire
